// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; clocked on i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, a, c)
`define ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/mar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_pkg
// Types and fixed widths of the minimum-area rectangle search.
// ----------------------------------------------------------------------------
package mar_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 33;
    localparam int BEST_W = 34;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD_I  = 6'b000010,
        S_RD_J  = 6'b000100,
        S_RUN_K = 6'b001000,
        S_FLUSH = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_PI   = 2'd1,
        K_PJ   = 2'd2,
        K_PK   = 2'd3
    } t_rd_kind;

    typedef struct packed {
        t_rd_kind kind;
        logic     cand;
        logic     last;
    } t_rd_ctl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } t_q_ctl;

endpackage

// ===== sv/mar_seq.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// mar_seq
// Point store and triple sequencer: walks corner i, pair j < k, one read a cycle.
// ----------------------------------------------------------------------------
module mar_seq #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_xfer,
    input  logic                  i_last,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  logic                  i_out_busy,
    input  logic                  i_done,
    output logic                  o_busy,
    output logic                  o_load,
    output mar_pkg::t_rd_ctl      o_rd_ctl,
    output logic [COORD_BITS-1:0] o_rd_x,
    output logic [COORD_BITS-1:0] o_rd_y
);
    import mar_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_k, n_k;
    logic [COORD_BITS-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] r_mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;
    t_rd_ctl         r_rd_ctl, w_rd_ctl;
    logic [AW-1:0]   w_addr;
    logic            w_load;
    logic [CW:0]     w_j_inc, w_k_inc;

    assign w_load  = i_in_xfer && (r_count < CW'(MAX_POINTS));
    assign w_j_inc = {1'b0, r_j} + 1'b1;
    assign w_k_inc = {1'b0, r_k} + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        w_addr   = r_i[AW-1:0];
        w_rd_ctl = '{kind: K_NONE, cand: 1'b0, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_xfer) begin
                    if (w_load) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                if (r_i == r_count) begin
                    n_state = S_FLUSH;
                end else begin
                    w_addr        = r_i[AW-1:0];
                    w_rd_ctl.kind = K_PI;
                    n_j           = '0;
                    n_state       = S_RD_J;
                end
            end
            S_RD_J: begin
                if (r_j == r_count) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RD_I;
                end else if ((r_j == r_i) || (w_j_inc >= {1'b0, r_count})) begin
                    n_j = r_j + 1'b1;
                end else begin
                    w_addr        = r_j[AW-1:0];
                    w_rd_ctl.kind = K_PJ;
                    n_k           = w_j_inc[CW-1:0];
                    n_state       = S_RUN_K;
                end
            end
            S_RUN_K: begin
                w_addr        = r_k[AW-1:0];
                w_rd_ctl.kind = K_PK;
                w_rd_ctl.cand = (r_k != r_i);
                if (w_k_inc == {1'b0, r_count}) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RD_J;
                end else begin
                    n_k = w_k_inc[CW-1:0];
                end
            end
            S_FLUSH: begin
                if (!i_out_busy) begin
                    w_rd_ctl.last = 1'b1;
                    n_state       = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_done) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_rd_ctl <= '{kind: K_NONE, cand: 1'b0, last: 1'b0};
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_rd_ctl <= w_rd_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem_x[r_count[AW-1:0]] <= i_px;
            r_mem_y[r_count[AW-1:0]] <= i_py;
        end
        if (w_rd_ctl.kind != K_NONE) begin
            r_rd_x <= r_mem_x[w_addr];
            r_rd_y <= r_mem_y[w_addr];
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_load   = w_load;
    assign o_rd_ctl = r_rd_ctl;
    assign o_rd_x   = r_rd_x;
    assign o_rd_y   = r_rd_y;

    `ASSERT_IMP(a_k_in_range, r_state == S_RUN_K, r_k < r_count)
    `ASSERT_IMP(a_j_not_corner, r_state == S_RUN_K, r_j != r_i)
    `ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_POINTS))

endmodule

// ===== sv/mar_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_geom
// Edge vectors, dot and cross products, fourth corner of each triple.
// ----------------------------------------------------------------------------
module mar_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mar_pkg::t_rd_ctl          i_rd_ctl,
    input  logic [COORD_BITS-1:0]     i_rd_x,
    input  logic [COORD_BITS-1:0]     i_rd_y,
    output mar_pkg::t_q_ctl           o_q_ctl,
    output logic [COORD_BITS-1:0]     o_qx,
    output logic [COORD_BITS-1:0]     o_qy,
    output logic [2*COORD_BITS:0]     o_area
);
    import mar_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PW    = 2 * CB + 2;
    localparam int AREAW = 2 * CB + 1;

    logic [CB-1:0]        r_xi, r_yi, r_xj, r_yj;
    logic signed [CB:0]   r_ax, r_ay;
    logic signed [CB:0]   w_dx, w_dy;
    logic [CB+1:0]        w_fx, w_fy;

    logic                 r_s1_v, r_s1_end, r_s1_grid;
    logic signed [CB:0]   r_s1_ax, r_s1_ay, r_s1_bx, r_s1_by;
    logic [CB-1:0]        r_s1_fx, r_s1_fy;

    logic                 r_s2_v, r_s2_end, r_s2_grid;
    logic signed [PW-1:0] r_p_xx, r_p_yy, r_p_xy, r_p_yx;
    logic [CB-1:0]        r_s2_fx, r_s2_fy;

    logic signed [PW:0]   w_dot, w_cross;
    logic [PW:0]          w_abs;

    t_q_ctl               r_q_ctl;
    logic [CB-1:0]        r_qx, r_qy;
    logic [AREAW-1:0]     r_area;

    assign w_dx = $signed({1'b0, i_rd_x}) - $signed({1'b0, r_xi});
    assign w_dy = $signed({1'b0, i_rd_y}) - $signed({1'b0, r_yi});
    assign w_fx = {2'b00, r_xj} + {2'b00, i_rd_x} - {2'b00, r_xi};
    assign w_fy = {2'b00, r_yj} + {2'b00, i_rd_y} - {2'b00, r_yi};

    assign w_dot   = (PW+1)'(r_p_xx) + (PW+1)'(r_p_yy);
    assign w_cross = (PW+1)'(r_p_xy) - (PW+1)'(r_p_yx);
    assign w_abs   = w_cross[PW] ? -w_cross : w_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_end <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s2_end <= 1'b0;
            r_q_ctl  <= '0;
        end else begin
            r_s1_v   <= (i_rd_ctl.kind == K_PK) && i_rd_ctl.cand;
            r_s1_end <= i_rd_ctl.last;
            r_s2_v   <= r_s1_v;
            r_s2_end <= r_s1_end;
            r_q_ctl.valid <= r_s2_v && r_s2_grid && (w_dot == '0) && (w_cross != '0);
            r_q_ctl.hit   <= 1'b0;
            r_q_ctl.last  <= r_s2_end;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_rd_ctl.kind)
            K_PI: begin
                r_xi <= i_rd_x;
                r_yi <= i_rd_y;
            end
            K_PJ: begin
                r_xj <= i_rd_x;
                r_yj <= i_rd_y;
                r_ax <= w_dx;
                r_ay <= w_dy;
            end
            K_PK: begin
                r_s1_ax   <= r_ax;
                r_s1_ay   <= r_ay;
                r_s1_bx   <= w_dx;
                r_s1_by   <= w_dy;
                r_s1_fx   <= w_fx[CB-1:0];
                r_s1_fy   <= w_fy[CB-1:0];
                r_s1_grid <= (w_fx[CB+1:CB] == 2'b00) && (w_fy[CB+1:CB] == 2'b00);
            end
            default: begin
            end
        endcase
        r_p_xx    <= r_s1_ax * r_s1_bx;
        r_p_yy    <= r_s1_ay * r_s1_by;
        r_p_xy    <= r_s1_ax * r_s1_by;
        r_p_yx    <= r_s1_ay * r_s1_bx;
        r_s2_fx   <= r_s1_fx;
        r_s2_fy   <= r_s1_fy;
        r_s2_grid <= r_s1_grid;
        r_qx      <= r_s2_fx;
        r_qy      <= r_s2_fy;
        r_area    <= w_abs[AREAW-1:0];
    end

    assign o_q_ctl = r_q_ctl;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_area  = r_area;

endmodule

// ===== sv/mar_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_cell
// One stored point; shifts points on load and marks queries that match it.
// ----------------------------------------------------------------------------
module mar_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_clr,
    input  logic                  i_pv,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    output logic                  o_pv,
    output logic [COORD_BITS-1:0] o_px,
    output logic [COORD_BITS-1:0] o_py,
    input  mar_pkg::t_q_ctl       i_q_ctl,
    input  logic [COORD_BITS-1:0] i_qx,
    input  logic [COORD_BITS-1:0] i_qy,
    input  logic [2*COORD_BITS:0] i_area,
    output mar_pkg::t_q_ctl       o_q_ctl,
    output logic [COORD_BITS-1:0] o_qx,
    output logic [COORD_BITS-1:0] o_qy,
    output logic [2*COORD_BITS:0] o_area
);
    import mar_pkg::*;

    logic                  r_v;
    logic [COORD_BITS-1:0] r_x, r_y;
    t_q_ctl                r_q_ctl;
    logic [COORD_BITS-1:0] r_qx, r_qy;
    logic [2*COORD_BITS:0] r_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_q_ctl <= '0;
        end else begin
            if (i_clr) begin
                r_v <= 1'b0;
            end else if (i_ld) begin
                r_v <= i_pv;
            end
            r_q_ctl.valid <= i_q_ctl.valid;
            r_q_ctl.last  <= i_q_ctl.last;
            r_q_ctl.hit   <= i_q_ctl.hit || (r_v && (r_x == i_qx) && (r_y == i_qy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_x <= i_px;
            r_y <= i_py;
        end
        r_qx   <= i_qx;
        r_qy   <= i_qy;
        r_area <= i_area;
    end

    assign o_pv    = r_v;
    assign o_px    = r_x;
    assign o_py    = r_y;
    assign o_q_ctl = r_q_ctl;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_area  = r_area;

endmodule

// ===== sv/min_area_rectangle_any_orientation_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// min_area_rectangle_any_orientation_unit
// Minimum-area rectangle of any orientation over a loaded point set.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+--------------------------------
//   input   | in        | i_valid / o_stall | i_x_coord, i_y_coord,
//           |           |                   | i_last_point
//   output  | out       | o_valid / i_stall | o_min_area, o_found
//
// Points load one per cycle while o_stall is low. After the last point the
// sequencer walks the triples with at most one store read per cycle, and
// the final query then travels down the cell row.
// Input is stalled from the last point until the result is registered.
// Reset clears control and the cell valid bits at once; no clearing pass.
// A result waits in the output register while the next set loads.
// ----------------------------------------------------------------------------
module min_area_rectangle_any_orientation_unit #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [mar_pkg::IN_W-1:0] i_x_coord,
    input  logic [mar_pkg::IN_W-1:0] i_y_coord,
    input  logic                     i_last_point,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [mar_pkg::OUT_W-1:0] o_min_area,
    output logic                     o_found
);
    import mar_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int AREAW = 2 * CB + 1;
    localparam int CMPW  = (AREAW > BEST_W) ? AREAW : BEST_W;

    logic              w_in_xfer, w_busy, w_load, w_done;
    logic [CB-1:0]     w_px, w_py;
    t_rd_ctl           w_rd_ctl;
    logic [CB-1:0]     w_rd_x, w_rd_y;

    logic              w_lv [MAX_POINTS];
    logic [CB-1:0]     w_lx [MAX_POINTS];
    logic [CB-1:0]     w_ly [MAX_POINTS];
    t_q_ctl            w_qc [MAX_POINTS+1];
    logic [CB-1:0]     w_qx [MAX_POINTS+1];
    logic [CB-1:0]     w_qy [MAX_POINTS+1];
    logic [AREAW-1:0]  w_qa [MAX_POINTS+1];

    t_q_ctl            w_tail;
    logic [CMPW-1:0]   w_area_ext, w_best_ext;

    logic [BEST_W-1:0] r_best;
    logic              r_found;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_area;
    logic              r_out_found;

    assign w_in_xfer = i_valid && !w_busy;
    assign w_px      = CB'(i_x_coord);
    assign w_py      = CB'(i_y_coord);

    mar_seq #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_xfer  (w_in_xfer),
        .i_last     (i_last_point),
        .i_px       (w_px),
        .i_py       (w_py),
        .i_out_busy (r_out_valid),
        .i_done     (w_done),
        .o_busy     (w_busy),
        .o_load     (w_load),
        .o_rd_ctl   (w_rd_ctl),
        .o_rd_x     (w_rd_x),
        .o_rd_y     (w_rd_y)
    );

    mar_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_ctl (w_rd_ctl),
        .i_rd_x   (w_rd_x),
        .i_rd_y   (w_rd_y),
        .o_q_ctl  (w_qc[0]),
        .o_qx     (w_qx[0]),
        .o_qy     (w_qy[0]),
        .o_area   (w_qa[0])
    );

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic          w_pv_in;
        logic [CB-1:0] w_px_in, w_py_in;
        if (g == 0) begin : g_head
            assign w_pv_in = 1'b1;
            assign w_px_in = w_px;
            assign w_py_in = w_py;
        end else begin : g_body
            assign w_pv_in = w_lv[g-1];
            assign w_px_in = w_lx[g-1];
            assign w_py_in = w_ly[g-1];
        end
        mar_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ld    (w_load),
            .i_clr   (w_done),
            .i_pv    (w_pv_in),
            .i_px    (w_px_in),
            .i_py    (w_py_in),
            .o_pv    (w_lv[g]),
            .o_px    (w_lx[g]),
            .o_py    (w_ly[g]),
            .i_q_ctl (w_qc[g]),
            .i_qx    (w_qx[g]),
            .i_qy    (w_qy[g]),
            .i_area  (w_qa[g]),
            .o_q_ctl (w_qc[g+1]),
            .o_qx    (w_qx[g+1]),
            .o_qy    (w_qy[g+1]),
            .o_area  (w_qa[g+1])
        );
    end

    assign w_tail     = w_qc[MAX_POINTS];
    assign w_done     = w_tail.last;
    assign w_area_ext = CMPW'(w_qa[MAX_POINTS]);
    assign w_best_ext = CMPW'(r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '1;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_tail.last) begin
                r_out_valid <= 1'b1;
                r_best      <= '1;
                r_found     <= 1'b0;
            end else if (w_tail.valid && w_tail.hit) begin
                r_found <= 1'b1;
                if (w_area_ext < w_best_ext) begin
                    r_best <= w_area_ext[BEST_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.last) begin
            r_out_area  <= r_found ? r_best[OUT_W-1:0] : '0;
            r_out_found <= r_found;
        end
    end

    assign o_stall    = w_busy;
    assign o_valid    = r_out_valid;
    assign o_min_area = r_out_area;
    assign o_found    = r_out_found;

    `ASSERT_NXT(a_done_loads_out, w_done, r_out_valid)
    `ASSERT_IMP(a_none_zero_area, r_out_valid && !r_out_found, r_out_area == '0)
    `ASSERT_NXT(a_best_only_falls, r_found && !w_done, r_best <= $past(r_best))

endmodule
